@@ hw/rtl/eva_pkg.sv @@
// Package for the eased value animator: register indexes, easing codes,
// reset values and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package eva_pkg;

    // Default width of the start, end and output values.
    localparam int VALUE_WIDTH_DEF = 16;

    // Configuration port geometry: six registers, word addressed.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register indexes (paddr[4:2]).
    localparam logic [2:0] REG_START_VALUE  = 3'd0;
    localparam logic [2:0] REG_END_VALUE    = 3'd1;
    localparam logic [2:0] REG_DURATION_MS  = 3'd2;
    localparam logic [2:0] REG_EASING_MODE  = 3'd3;
    localparam logic [2:0] REG_AUTOREVERSE  = 3'd4;
    localparam logic [2:0] REG_REPEAT_TOTAL = 3'd5;

    // Easing curve codes.
    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_IN     = 2'd1;
    localparam logic [1:0] CURVE_OUT    = 2'd2;
    localparam logic [1:0] CURVE_IN_OUT = 2'd3;

    // Register reset values that are not zero.
    localparam logic [15:0] DURATION_RESET = 16'd1000;
    localparam logic [7:0]  REPEAT_RESET   = 8'd1;

    // 16-bit fraction fixed point: one (Q1.16), and two as the out curve operand base.
    localparam logic [16:0] Q_ONE = 17'h10000;
    localparam logic [17:0] Q_TWO = 18'h20000;

    // Signed operand side B of the shared multiplier, non-negative values (18 bits plus sign).
    localparam int MUL_B_W = 19;

endpackage

@@ hw/rtl/eased_value_animator.sv @@
// Eased value animator: one fade channel with a serial divider and one
// shared multiplier under a small sequencer. Depends on eva_pkg.
`timescale 1ns / 1ps

// A tick item inside its pass goes through setup, the sixteen divider steps, then the
// easing, blend and output steps; a tick that reaches the end of its pass skips the
// divider, and an idle tick goes straight to the output step.
// The block takes no new item until the last one has been handed to the output register;
// the divider yields one quotient bit per cycle; a stalled result holds off the next item.
// Reset (i_rst_n low, synchronous) clears the animation and loads duration 1000, repeats 1.
module eased_value_animator #(
    parameter int VALUE_WIDTH = eva_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Tick items in.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_start_req,
    input  logic [15:0]                   i_delta_ms,

    // Result items out.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic [16:0]                   o_eased_progress,
    output logic                          o_running,
    output logic                          o_done_res,

    // APB-style configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [eva_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [eva_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [eva_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready
);

    // The shared multiplier is signed on both sides. Side A carries either
    // the blend difference (one bit wider than a value) or a 17-bit easing
    // operand, so it is as wide as the difference or as side B, if that is wider.
    localparam int MUL_A_W = (VALUE_WIDTH + 1 > eva_pkg::MUL_B_W) ?
                             VALUE_WIDTH + 1 : eva_pkg::MUL_B_W;
    localparam int PROD_W  = MUL_A_W + eva_pkg::MUL_B_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_EASE_MUL,
        S_EASE_FIX,
        S_BLEND_MUL,
        S_BLEND_FIX,
        S_FINISH
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [VALUE_WIDTH-1:0] r_start_value;
    logic signed [VALUE_WIDTH-1:0] r_end_value;
    logic [15:0]                   r_duration_ms;
    logic [1:0]                    r_easing_mode;
    logic                          r_autoreverse;
    logic [7:0]                    r_repeat_total;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_value  <= '0;
            r_end_value    <= '0;
            r_duration_ms  <= eva_pkg::DURATION_RESET;
            r_easing_mode  <= eva_pkg::CURVE_LINEAR;
            r_autoreverse  <= 1'b0;
            r_repeat_total <= eva_pkg::REPEAT_RESET;
        end else if (cfg_write) begin
            // Addresses past the last register are ignored.
            unique case (cfg_index)
                eva_pkg::REG_START_VALUE:  r_start_value  <= pwdata[VALUE_WIDTH-1:0];
                eva_pkg::REG_END_VALUE:    r_end_value    <= pwdata[VALUE_WIDTH-1:0];
                eva_pkg::REG_DURATION_MS:  r_duration_ms  <= pwdata[15:0];
                eva_pkg::REG_EASING_MODE:  r_easing_mode  <= pwdata[1:0];
                eva_pkg::REG_AUTOREVERSE:  r_autoreverse  <= pwdata[0];
                eva_pkg::REG_REPEAT_TOTAL: r_repeat_total <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read data; the signed values are sign-extended to the bus width.
    always_comb begin
        unique case (cfg_index)
            eva_pkg::REG_START_VALUE:  prdata = eva_pkg::CFG_DATA_W'(r_start_value);
            eva_pkg::REG_END_VALUE:    prdata = eva_pkg::CFG_DATA_W'(r_end_value);
            eva_pkg::REG_DURATION_MS:  prdata = eva_pkg::CFG_DATA_W'(r_duration_ms);
            eva_pkg::REG_EASING_MODE:  prdata = eva_pkg::CFG_DATA_W'(r_easing_mode);
            eva_pkg::REG_AUTOREVERSE:  prdata = eva_pkg::CFG_DATA_W'(r_autoreverse);
            eva_pkg::REG_REPEAT_TOTAL: prdata = eva_pkg::CFG_DATA_W'(r_repeat_total);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Animation state and sequencer registers.
    // ------------------------------------------------------------------
    t_state                        r_state;
    logic [16:0]                   r_elapsed;   // elapsed time of the current pass
    logic [8:0]                    r_pass;      // passes completed
    logic                          r_rev;       // 1 on a reverse pass
    logic                          r_active;    // animation is running
    logic signed [VALUE_WIDTH-1:0] r_held;      // last value, held when idle

    logic                          r_reach;     // this tick ends the pass
    logic [15:0]                   r_rem;       // divider partial remainder
    logic [16:0]                   r_t;         // progress, Q1.16, built by the divider
    logic [3:0]                    r_cnt;       // divider step
    logic [16:0]                   r_eased;
    logic                          r_done;
    logic signed [VALUE_WIDTH-1:0] r_base;      // start point of this pass
    logic signed [VALUE_WIDTH:0]   r_diff;      // end point minus start point
    logic signed [PROD_W-1:0]      r_prod;

    // Output register.
    logic                          r_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_out_value;
    logic [16:0]                   r_out_eased;
    logic                          r_out_running;
    logic                          r_out_done;

    // ------------------------------------------------------------------
    // Datapath helpers.
    // ------------------------------------------------------------------
    logic                          in_accept;
    logic                          active_now;
    logic [16:0]                   elapsed_sum;
    logic [15:0]                   dur_eff;
    logic                          reach_now;
    logic [16:0]                   rem_shift;
    logic                          rem_ge;
    logic                          t_low_half;
    logic [16:0]                   u_mirror;
    logic [16:0]                   eased_calc;
    logic signed [VALUE_WIDTH-1:0] blend_value;
    logic [8:0]                    n_pass;
    logic [7:0]                    reps_eff;
    logic [8:0]                    pass_total;
    logic                          out_free;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [eva_pkg::MUL_B_W-1:0] mul_b;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // A start request restarts from zero elapsed before the delta is added.
    assign active_now  = i_start_req || r_active;
    assign elapsed_sum = (i_start_req ? 17'd0 : r_elapsed) + 17'(i_delta_ms);

    // A zero duration behaves as one millisecond.
    assign dur_eff   = (r_duration_ms == 16'd0) ? 16'd1 : r_duration_ms;
    assign reach_now = (r_elapsed >= 17'(dur_eff));

    // Restoring division, one quotient bit per cycle. The remainder stays
    // below the divisor, so its doubled value fits in 17 bits.
    assign rem_shift = {r_rem, 1'b0};
    assign rem_ge    = (rem_shift >= 17'(dur_eff));

    assign t_low_half = (r_t < {2'b01, 15'd0});
    assign u_mirror   = eva_pkg::Q_ONE - r_t;

    // Shared multiplier operands, chosen by the sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_EASE_MUL: begin
                unique case (r_easing_mode)
                    eva_pkg::CURVE_OUT: begin
                        mul_a = MUL_A_W'(r_t);
                        mul_b = eva_pkg::MUL_B_W'(eva_pkg::Q_TWO - 18'(r_t));
                    end
                    eva_pkg::CURVE_IN_OUT: begin
                        // Lower half squares t, upper half squares 1 - t.
                        mul_a = t_low_half ? MUL_A_W'(r_t) : MUL_A_W'(u_mirror);
                        mul_b = t_low_half ? eva_pkg::MUL_B_W'(r_t) :
                                             eva_pkg::MUL_B_W'(u_mirror);
                    end
                    eva_pkg::CURVE_IN, eva_pkg::CURVE_LINEAR: begin
                        mul_a = MUL_A_W'(r_t);
                        mul_b = eva_pkg::MUL_B_W'(r_t);
                    end
                    default: ;
                endcase
            end
            S_BLEND_MUL: begin
                mul_a = MUL_A_W'(r_diff);
                mul_b = eva_pkg::MUL_B_W'(r_eased);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Easing result from the registered product; the linear curve passes t through.
    always_comb begin
        unique case (r_easing_mode)
            eva_pkg::CURVE_LINEAR: eased_calc = r_t;
            eva_pkg::CURVE_IN,
            eva_pkg::CURVE_OUT:    eased_calc = r_prod[32:16];
            eva_pkg::CURVE_IN_OUT: eased_calc = t_low_half ? r_prod[31:15] :
                                                eva_pkg::Q_ONE - r_prod[31:15];
            default:               eased_calc = r_t;
        endcase
    end

    // The arithmetic shift of the product floors toward minus infinity, and
    // the sum wraps to the value width.
    assign blend_value = r_base + r_prod[VALUE_WIDTH+15:16];

    // Pass bookkeeping: zero repeats acts as one, autoreverse doubles it.
    assign n_pass     = r_pass + 9'd1;
    assign reps_eff   = (r_repeat_total == 8'd0) ? 8'd1 : r_repeat_total;
    assign pass_total = r_autoreverse ? {reps_eff, 1'b0} : {1'b0, reps_eff};

    // ------------------------------------------------------------------
    // Sequencer with animation state and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_pass      <= '0;
            r_rev       <= 1'b0;
            r_active    <= 1'b0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_FINISH the output is refilled in the cycle the old item leaves.
            if (r_out_valid && !i_out_stall && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_done  <= 1'b0;
                        r_eased <= '0;
                        if (i_start_req) begin
                            r_pass   <= '0;
                            r_rev    <= 1'b0;
                            r_active <= 1'b1;
                        end
                        if (active_now) begin
                            r_elapsed <= elapsed_sum;
                            r_state   <= S_SETUP;
                        end else begin
                            // Idle tick: report the held value only.
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_SETUP: begin
                    r_reach <= reach_now;
                    r_cnt   <= '0;
                    r_rem   <= reach_now ? 16'd0 : r_elapsed[15:0];
                    r_t     <= reach_now ? eva_pkg::Q_ONE : 17'd0;
                    r_base  <= r_rev ? r_end_value : r_start_value;
                    r_diff  <= r_rev ?
                               (VALUE_WIDTH+1)'(r_start_value) - (VALUE_WIDTH+1)'(r_end_value) :
                               (VALUE_WIDTH+1)'(r_end_value) - (VALUE_WIDTH+1)'(r_start_value);
                    r_state <= reach_now ? S_EASE_MUL : S_DIV;
                end
                S_DIV: begin
                    r_rem <= rem_ge ? 16'(rem_shift - 17'(dur_eff)) : rem_shift[15:0];
                    r_t   <= {r_t[15:0], rem_ge};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_EASE_MUL;
                    end
                end
                S_EASE_MUL: begin
                    r_state <= S_EASE_FIX;
                end
                S_EASE_FIX: begin
                    r_eased <= eased_calc;
                    r_state <= S_BLEND_MUL;
                end
                S_BLEND_MUL: begin
                    r_state <= S_BLEND_FIX;
                end
                S_BLEND_FIX: begin
                    r_held <= blend_value;
                    if (r_reach) begin
                        r_pass <= n_pass;
                        if (n_pass >= pass_total) begin
                            r_active <= 1'b0;
                            r_done   <= 1'b1;
                        end else begin
                            // Overshoot is dropped; the next pass starts at zero.
                            r_elapsed <= '0;
                            if (r_autoreverse) begin
                                r_rev <= !r_rev;
                            end
                        end
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_value   <= r_held;
                        r_out_eased   <= r_eased;
                        r_out_running <= r_active;
                        r_out_done    <= r_done;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_value          = r_out_value;
    assign o_eased_progress = r_out_eased;
    assign o_running        = r_out_running;
    assign o_done_res       = r_out_done;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_div_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> 17'(r_rem) < 17'(dur_eff))
        else $error("divider remainder not below the duration");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_cnt == 4'd15 |=> r_state == S_EASE_MUL)
        else $error("divider did not finish after sixteen steps");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_running && o_eased_progress == eva_pkg::Q_ONE)
        else $error("done item does not end the animation at full progress");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_running && !o_done_res |-> o_eased_progress == 17'd0)
        else $error("idle item carries progress");

    a_progress_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BLEND_MUL |-> r_eased <= eva_pkg::Q_ONE)
        else $error("eased progress above one");

endmodule

@@ tb/tb_eased_value_animator.sv @@
// Self-checking testbench for the eased value animator: directed fade
// sequences from a table, then randomized runs scored by a local predictor.
// Depends on eva_pkg and the eased_value_animator RTL only.
`timescale 1ns / 1ps

module tb_eased_value_animator;

    localparam int VW = eva_pkg::VALUE_WIDTH_DEF;

    // Sized to an active tick's pass through the block, which is longer than
    // an idle one's; used as settling time before register writes.
    localparam int ACTIVE_LAT = 22;

    // Longest legal silence: a long source gap or sink stall, the block's
    // own latency and the settling waits around register writes. The limit
    // is many times that.
    localparam int STALL_LIMIT = 3000;

    // Minimum number of tick items sent over the whole run, directed rows included.
    localparam int TICK_GOAL = 850;

    // One result item as the block reports it.
    typedef struct packed {
        logic [VW-1:0] value;
        logic [16:0]   progress;
        logic          running;
        logic          done;
    } t_frame;

    typedef enum logic {STEP_REG, STEP_TICK} t_step_kind;

    // One row of the directed plan: either a register write or a tick item.
    // When typed is set, the row carries its own expected result.
    typedef struct packed {
        t_step_kind  kind;
        logic [2:0]  reg_idx;
        logic [31:0] reg_data;
        logic        start;
        logic [15:0] delta;
        logic        typed;
        t_frame      want;
    } t_step;

    localparam logic [VW-1:0] LEVEL_MIN = {1'b1, {(VW - 1){1'b0}}};
    localparam logic [VW-1:0] LEVEL_MAX = ~LEVEL_MIN;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input is known from time zero.
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    logic          i_start_req = 1'b0;
    logic [15:0]   i_delta_ms = '0;

    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    logic [VW-1:0] o_value;
    logic [16:0]   o_eased_progress;
    logic          o_running;
    logic          o_done_res;

    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [eva_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [eva_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [eva_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    eased_value_animator #(
        .VALUE_WIDTH(VW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_start_req     (i_start_req),
        .i_delta_ms      (i_delta_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_value         (o_value),
        .o_eased_progress(o_eased_progress),
        .o_running       (o_running),
        .o_done_res      (o_done_res),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers and of the channel.
    // The register copy changes at the same edge as the block's registers.
    // ------------------------------------------------------------------
    logic signed [VW-1:0] cfg_start = '0;
    logic signed [VW-1:0] cfg_end = '0;
    logic [15:0]          cfg_duration = eva_pkg::DURATION_RESET;
    logic [1:0]           cfg_mode = eva_pkg::CURVE_LINEAR;
    logic                 cfg_reverse_en = 1'b0;
    logic [7:0]           cfg_repeats = eva_pkg::REPEAT_RESET;

    logic [16:0]   anim_elapsed = '0;
    logic [8:0]    anim_passes = '0;
    logic          anim_backward = 1'b0;
    logic          anim_active = 1'b0;
    logic [VW-1:0] anim_hold = '0;

    // Results still owed by the block, oldest first.
    t_frame frames_due[$];

    // Run bookkeeping.
    int  mismatches = 0;
    int  results_checked = 0;
    int  ticks_sent = 0;
    int  live_ticks = 0;
    int  pass_ends = 0;
    int  finished_runs = 0;
    int  phases = 0;
    int  quiet_cycles = 0;
    int  sink_hold = 0;
    logic calm_run = 1'b0;

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            eva_pkg::REG_START_VALUE:  cfg_start = data[VW-1:0];
            eva_pkg::REG_END_VALUE:    cfg_end = data[VW-1:0];
            eva_pkg::REG_DURATION_MS:  cfg_duration = data[15:0];
            eva_pkg::REG_EASING_MODE:  cfg_mode = data[1:0];
            eva_pkg::REG_AUTOREVERSE:  cfg_reverse_en = data[0];
            eva_pkg::REG_REPEAT_TOTAL: cfg_repeats = data[7:0];
            default: ;
        endcase
    endfunction

    // Advances the channel by one tick item and returns the result it owes.
    function automatic t_frame advance_channel(input logic start, input logic [15:0] delta);
        t_frame f;
        longint unsigned dur, clamped, frac, eased, rest, reps, total;
        longint a, b, mixed;
        f = '0;
        if (start) begin
            anim_elapsed = '0;
            anim_passes = '0;
            anim_backward = 1'b0;
            anim_active = 1'b1;
        end
        // An idle channel ignores the delta and keeps showing its last value.
        if (!anim_active) begin
            f.value = anim_hold;
            return f;
        end

        // A zero duration behaves as one millisecond.
        dur = (cfg_duration == 16'd0) ? 1 : cfg_duration;
        anim_elapsed = anim_elapsed + delta;
        clamped = (anim_elapsed < dur) ? anim_elapsed : dur;
        frac = (clamped << 16) / dur;

        case (cfg_mode)
            eva_pkg::CURVE_IN:  eased = (frac * frac) >> 16;
            eva_pkg::CURVE_OUT: eased = (frac * (eva_pkg::Q_TWO - frac)) >> 16;
            eva_pkg::CURVE_IN_OUT: begin
                if (frac < eva_pkg::Q_ONE / 2) begin
                    eased = (2 * frac * frac) >> 16;
                end else begin
                    rest = eva_pkg::Q_ONE - frac;
                    eased = eva_pkg::Q_ONE - ((2 * rest * rest) >> 16);
                end
            end
            default:  eased = frac;
        endcase

        // A reverse pass runs from the end value back to the start value.
        a = anim_backward ? cfg_end : cfg_start;
        b = anim_backward ? cfg_start : cfg_end;
        mixed = a + (((b - a) * longint'(eased)) >>> 16);
        anim_hold = mixed[VW-1:0];

        // Reaching the duration ends the pass; overshoot is dropped.
        if (anim_elapsed >= dur) begin
            reps = (cfg_repeats == 8'd0) ? 1 : cfg_repeats;
            total = cfg_reverse_en ? 2 * reps : reps;
            anim_passes = anim_passes + 1'b1;
            pass_ends++;
            if (anim_passes >= total) begin
                anim_active = 1'b0;
                f.done = 1'b1;
                finished_runs++;
            end else begin
                anim_elapsed = '0;
                if (cfg_reverse_en) begin
                    anim_backward = ~anim_backward;
                end
            end
        end

        f.value = anim_hold;
        f.progress = eased[16:0];
        f.running = anim_active;
        return f;
    endfunction

    // Gap lengths: mostly none, some short, a few long. A calm run has none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_run || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // Deltas are scaled to the pass length so that passes end often, with
    // exact landings on the pass end, small overshoots and raw 16-bit noise.
    function automatic logic [15:0] pick_delta();
        longint unsigned dur, remaining;
        int r;
        dur = (cfg_duration == 16'd0) ? 1 : cfg_duration;
        remaining = (anim_elapsed < dur) ? dur - anim_elapsed : 0;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'd0;
        if (r < 25) return 16'(remaining);
        if (r < 35) return 16'(remaining + $urandom_range(1, 5));
        if (r < 45) return 16'($urandom);
        return 16'($urandom_range(0, 32'(dur / 3 + 1)));
    endfunction

    function automatic logic [VW-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return LEVEL_MIN;
            1: return LEVEL_MAX;
            default: return VW'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Source side: offers one tick item, waits for it to be taken, records
    // the result it owes, then idles for a random gap. With no gap, valid
    // simply stays high into the next item.
    // ------------------------------------------------------------------
    task automatic send_tick(input logic start, input logic [15:0] delta,
                             input logic typed, input t_frame typed_want);
        t_frame f;
        int gap;
        i_in_valid <= 1'b1;
        i_start_req <= start;
        i_delta_ms <= delta;
        do @(posedge i_clk); while (o_in_stall);
        if (start || anim_active) begin
            live_ticks++;
        end
        ticks_sent++;
        f = advance_channel(start, delta);
        frames_due.push_back(typed ? typed_want : f);
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds the source back until every owed result has come out and the
    // block has had time to settle. Register writes only follow this.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (ACTIVE_LAT + 2) @(posedge i_clk);
    endtask

    // Setup cycle, access cycle, then an idle cycle so that back-to-back
    // writes never assign the strobes twice in one time step.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_reg(idx, data);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Rewrites a random subset of the registers, favoring short passes and
    // few repeats but now and then taking the extremes.
    task automatic retune();
        logic [15:0] dur;
        logic [7:0]  reps;
        wait_quiet();
        if ($urandom_range(0, 1)) write_reg(eva_pkg::REG_START_VALUE, 32'(pick_level()));
        if ($urandom_range(0, 1)) write_reg(eva_pkg::REG_END_VALUE, 32'(pick_level()));
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0:       dur = 16'd0;
                1:       dur = 16'hFFFF;
                2:       dur = 16'd1;
                3, 4:    dur = 16'($urandom_range(41, 3000));
                default: dur = 16'($urandom_range(2, 40));
            endcase
            write_reg(eva_pkg::REG_DURATION_MS, 32'(dur));
        end
        if ($urandom_range(0, 1)) begin
            write_reg(eva_pkg::REG_EASING_MODE, 32'($urandom_range(0, 3)));
        end
        if ($urandom_range(0, 1)) begin
            write_reg(eva_pkg::REG_AUTOREVERSE, 32'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
                0:       reps = 8'd0;
                1:       reps = 8'hFF;
                default: reps = 8'($urandom_range(1, 3));
            endcase
            write_reg(eva_pkg::REG_REPEAT_TOTAL, 32'(reps));
        end
    endtask

    // ------------------------------------------------------------------
    // Directed plan. Rows with a typed result are the ones whose answer is
    // plain: the idle channel after reset, one-millisecond passes that jump
    // straight to the end value, and the full-scale swing in both
    // directions. All other rows are scored by the predictor.
    // ------------------------------------------------------------------
    localparam int PLAN_LEN = 39;

    t_step plan [PLAN_LEN] = '{
        // Idle after reset: the delta is ignored and zero is held.
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'hFFFF, 1'b1, {16'h0000, 17'h0, 1'b0, 1'b0}},
        // Full-scale forward swing over a one-millisecond pass.
        '{STEP_REG, eva_pkg::REG_START_VALUE, 32'(LEVEL_MIN), 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_END_VALUE, 32'(LEVEL_MAX), 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_DURATION_MS, 32'd1, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_EASING_MODE, 32'(eva_pkg::CURVE_LINEAR), 1'b0, 16'd0,
          1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b1, 16'h0000, 1'b1, {16'h8000, 17'h0, 1'b1, 1'b0}},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'h0001, 1'b1, {16'h7FFF, 17'h10000, 1'b0, 1'b1}},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'hFFFF, 1'b1, {16'h7FFF, 17'h0, 1'b0, 1'b0}},
        // Zero duration and zero repeats, autoreversed: two whole passes.
        '{STEP_REG, eva_pkg::REG_DURATION_MS, 32'd0, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_EASING_MODE, 32'(eva_pkg::CURVE_IN), 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_AUTOREVERSE, 32'd1, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_REPEAT_TOTAL, 32'd0, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b1, 16'hFFFF, 1'b1, {16'h7FFF, 17'h10000, 1'b1, 1'b0}},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'h0005, 1'b1, {16'h8000, 17'h10000, 1'b0, 1'b1}},
        // Longest pass, the out curve, most repeats, then a restart mid-pass.
        '{STEP_REG, eva_pkg::REG_START_VALUE, 32'd100, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_END_VALUE, 32'h0000_FF9C, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_DURATION_MS, 32'hFFFF, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_EASING_MODE, 32'(eva_pkg::CURVE_OUT), 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_AUTOREVERSE, 32'd0, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_REPEAT_TOTAL, 32'hFF, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b1, 16'h8000, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'h7FFF, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'h0000, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b1, 16'h1234, 1'b0, '0},
        // The in-out curve right at its half-way seam.
        '{STEP_REG, eva_pkg::REG_DURATION_MS, 32'd2, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_EASING_MODE, 32'(eva_pkg::CURVE_IN_OUT), 1'b0, 16'd0,
          1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b1, 16'h0001, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'h0000, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'h0001, 1'b0, '0},
        // Two autoreversed repeats with an overshooting first tick.
        '{STEP_REG, eva_pkg::REG_DURATION_MS, 32'd1000, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_EASING_MODE, 32'(eva_pkg::CURVE_LINEAR), 1'b0, 16'd0,
          1'b0, '0},
        '{STEP_REG, eva_pkg::REG_REPEAT_TOTAL, 32'd2, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_REG, eva_pkg::REG_AUTOREVERSE, 32'd1, 1'b0, 16'd0, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b1, 16'd1500, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'd999, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'd1, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'hFFFF, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'hFFFF, 1'b0, '0},
        '{STEP_TICK, 3'd0, 32'd0, 1'b0, 16'h0000, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Sink side: random stalls of mixed length; none start during a calm run.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (!calm_run && $urandom_range(0, 2) == 0) begin
            i_out_stall <= 1'b1;
            sink_hold <= pick_gap();
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Every accepted result is matched against the oldest owed one.
    always @(posedge i_clk) begin
        t_frame want;
        t_frame seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.value = o_value;
            seen.progress = o_eased_progress;
            seen.running = o_running;
            seen.done = o_done_res;
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected result, actual value %0h progress %0h",
                         $time, seen.value, seen.progress);
                mismatches++;
            end else begin
                want = frames_due.pop_front();
                results_checked++;
                check_field("value", 32'(want.value), 32'(seen.value));
                check_field("eased_progress", 32'(want.progress), 32'(seen.progress));
                check_field("running", 32'(want.running), 32'(seen.running));
                check_field("done_res", 32'(want.done), 32'(seen.done));
            end
        end
    end

    // Counts cycles in which no item, result or register write moves.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: nothing moved for %0d cycles, %0d results still owed",
                 $time, STALL_LIMIT, frames_due.size());
        $display("tb_eased_value_animator: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed plan, then randomized fade runs.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int budget;
        int n;
        logic noisy;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_REG) begin
                wait_quiet();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                send_tick(plan[i].start, plan[i].delta, plan[i].typed, plan[i].want);
            end
        end

        // Each random phase is mostly a well-formed run: a start tick, then
        // ticks until the run finishes or the phase budget is spent. A noisy
        // phase mixes in restarts, and up to two ticks at the end hit the channel,
        // idle once the run has finished. Some phases run with neither side pausing.
        while (ticks_sent < TICK_GOAL) begin
            phases++;
            if (phases == 1 || $urandom_range(0, 3) != 0) begin
                retune();
            end
            calm_run = ($urandom_range(0, 4) == 0);
            noisy = ($urandom_range(0, 5) == 0);
            budget = $urandom_range(4, 40);
            send_tick(1'b1, pick_delta(), 1'b0, '0);
            for (int k = 0; k < budget && anim_active; k++) begin
                send_tick(noisy && $urandom_range(0, 7) == 0,
                          noisy ? 16'($urandom) : pick_delta(), 1'b0, '0);
            end
            n = $urandom_range(0, 2);
            repeat (n) send_tick(1'b0, 16'($urandom), 1'b0, '0);
        end

        // Drain: everything owed must arrive, then nothing more may follow.
        i_in_valid <= 1'b0;
        calm_run = 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (2 * ACTIVE_LAT) @(posedge i_clk);

        $display("Covered %0d tick items (%0d on a running channel) over %0d phases,",
                 ticks_sent, live_ticks, phases);
        $display("with %0d pass ends, %0d finished runs and %0d results checked.",
                 pass_ends, finished_runs, results_checked);
        if (mismatches == 0) begin
            $display("tb_eased_value_animator: PASS");
        end else begin
            $display("tb_eased_value_animator: FAIL");
        end
        $finish;
    end

endmodule

@@ eased_value_animator.f @@
hw/rtl/eva_pkg.sv
hw/rtl/eased_value_animator.sv
tb/tb_eased_value_animator.sv
